FILE: rtl/ordered_insertion_list_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ordered insertion list
// Clocked property shorthands with reset disable, same cycle and next cycle.
// ---------------------------------------------------------------------------
`ifndef ORDERED_INSERTION_LIST_ASSERT_SVH
`define ORDERED_INSERTION_LIST_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define OIL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ordered insertion list check failed");

// antecedent implies consequent in the following cycle
`define OIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ordered insertion list check failed");

`endif

FILE: rtl/oil_pkg.sv
// ---------------------------------------------------------------------------
// oil_pkg
// Types and fixed widths shared by the ordered insertion list modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package oil_pkg;

	localparam int MODE_W      = 3;
	localparam int POS_W       = 5;
	localparam int HANDLE_W    = 8;
	localparam int KEY_W       = 16;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 5;

	typedef enum logic [MODE_W-1:0] {
		MODE_INS_POS = 3'd0,
		MODE_INS_KEY = 3'd1,
		MODE_POP     = 3'd2,
		MODE_REMOVE  = 3'd3,
		MODE_CLEAR   = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE    = 2'd0,
		STAT_BAD_POS = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_MISS    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_REPORT
	} seq_state_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_HIT_KEY,
		CELL_HIT_HANDLE,
		CELL_RIPPLE,
		CELL_INS_POS,
		CELL_INS_KEY,
		CELL_POP,
		CELL_REMOVE
	} cell_op_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		cell_op_t              op;
		logic [HANDLE_W-1:0]   handle;
		logic [KEY_W-1:0]      key;
		logic [POS_W-1:0]      pos;
	} cell_ctl_t;

	// gathered from the cell row for the sequencer
	typedef struct packed {
		logic                  found;
		logic [HANDLE_W-1:0]   head_handle;
		logic [KEY_W-1:0]      head_key;
		logic [HANDLE_W-1:0]   tail_handle;
	} seq_obs_t;

	typedef struct packed {
		logic [MODE_W-1:0]     mode;
		logic [POS_W-1:0]      position;
		logic [HANDLE_W-1:0]   item_handle;
		logic [KEY_W-1:0]      arrival_key;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic                   popped_valid;
		logic [HANDLE_W-1:0]    popped_handle;
		logic [KEY_W-1:0]       popped_key;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic                   nonempty;
		logic [HANDLE_W-1:0]    head_handle;
		logic [HANDLE_W-1:0]    tail_handle;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/oil_if.sv
// ---------------------------------------------------------------------------
// oil_if
// Valid/ready channels for list commands and list results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface oil_cmd_if import oil_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface oil_res_if import oil_pkg::*; ();
	logic valid;
	logic ready;
	res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/oil_cell.sv
// ---------------------------------------------------------------------------
// oil_cell
// One list slot: holds an entry, a hit flag and a ripple mark, and moves
// entries to or from its neighbors as the broadcast operation says.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oil_cell import oil_pkg::*; #(
	parameter int CW  = 5,
	parameter int IDX = 0
) (
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  logic [CW-1:0]       count,
	input  logic [HANDLE_W-1:0] prev_handle,
	input  logic [KEY_W-1:0]    prev_key,
	input  logic                prev_mark,
	input  logic [HANDLE_W-1:0] next_handle,
	input  logic [KEY_W-1:0]    next_key,
	output logic [HANDLE_W-1:0] handle,
	output logic [KEY_W-1:0]    key,
	output logic                mark,
	output logic [HANDLE_W-1:0] tail_handle,
	output logic                last_mark
);

	localparam int XW = (CW > POS_W) ? CW : POS_W;

	logic [XW-1:0]       idx_x;
	logic [XW-1:0]       idx_next_x;
	logic [XW-1:0]       count_x;
	logic [XW-1:0]       pos_x;
	logic                occupied;
	logic                is_last;
	logic                at_pos;
	logic                past_pos;
	logic                at_count;
	logic [HANDLE_W-1:0] handle_q;
	logic [KEY_W-1:0]    key_q;
	logic                hit_q;
	logic                mark_q;

	assign idx_x      = XW'(IDX);
	assign idx_next_x = XW'(IDX + 1);
	assign count_x    = XW'(count);
	assign pos_x      = XW'(ctl.pos);
	assign occupied   = idx_x < count_x;
	assign is_last    = idx_next_x == count_x;
	assign at_pos     = idx_x == pos_x;
	assign past_pos   = idx_x > pos_x;
	assign at_count   = idx_x == count_x;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_HOLD: begin
			end
			CELL_HIT_KEY: begin
				hit_q  <= occupied && (key_q > ctl.key);
				mark_q <= 1'b0;
			end
			CELL_HIT_HANDLE: begin
				hit_q  <= occupied && (handle_q == ctl.handle);
				mark_q <= 1'b0;
			end
			CELL_RIPPLE: begin
				mark_q <= prev_mark | hit_q;
			end
			CELL_INS_POS: begin
				if (at_pos) begin
					handle_q <= ctl.handle;
					key_q    <= ctl.key;
				end else if (past_pos) begin
					handle_q <= prev_handle;
					key_q    <= prev_key;
				end
			end
			CELL_INS_KEY: begin
				// first marked cell takes the new entry, later ones shift up
				if (mark_q) begin
					if (prev_mark) begin
						handle_q <= prev_handle;
						key_q    <= prev_key;
					end else begin
						handle_q <= ctl.handle;
						key_q    <= ctl.key;
					end
				end else if (at_count) begin
					handle_q <= ctl.handle;
					key_q    <= ctl.key;
				end
			end
			CELL_POP: begin
				handle_q <= next_handle;
				key_q    <= next_key;
			end
			CELL_REMOVE: begin
				if (mark_q) begin
					handle_q <= next_handle;
					key_q    <= next_key;
				end
			end
			default: begin
			end
		endcase
	end

	assign handle      = handle_q;
	assign key         = key_q;
	assign mark        = mark_q;
	assign tail_handle = is_last ? handle_q : '0;
	assign last_mark   = is_last & mark_q;

endmodule

`default_nettype wire

FILE: rtl/oil_seq.sv
// ---------------------------------------------------------------------------
// oil_seq
// Command sequencer: takes a command, runs the mark ripple when a search is
// needed, applies the edit to the cell row and loads the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oil_seq import oil_pkg::*; #(
	parameter int CAPACITY = 16,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	oil_cmd_if.sink       cmd,
	oil_res_if.source     res,
	input  seq_obs_t      obs,
	output cell_ctl_t     ctl,
	output logic [CW-1:0] count
);

	localparam int XW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	seq_state_t          state_q;
	seq_state_t          state_d;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_a;
	logic [CW-1:0]       step_q;
	logic [CW-1:0]       step_inc;
	logic [CW-1:0]       target_q;
	cmd_t                cmd_q;
	status_t             status_q;
	status_t             status_a;
	logic                pop_a;
	logic                pop_valid_q;
	logic [HANDLE_W-1:0] pop_handle_q;
	logic [KEY_W-1:0]    pop_key_q;
	logic                res_valid_q;
	res_t                res_q;
	logic                accept;
	logic                res_free;
	logic                full;
	logic                empty;
	logic                need_scan;
	logic                pos_bad;

	assign accept   = cmd.valid && cmd.ready;
	assign res_free = !res_valid_q || res.ready;
	assign full     = count_q == CAP_C;
	assign empty    = count_q == '0;
	assign step_inc = CW'(step_q + 1'b1);
	assign pos_bad  = XW'(cmd_q.position) > XW'(count_q);
	assign need_scan = ((cmd.payload.mode == MODE_INS_KEY) && !full) ||
		((cmd.payload.mode == MODE_REMOVE) && !empty);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = need_scan ? S_SCAN : S_APPLY;
				end
			end
			S_SCAN: begin
				if (step_inc == target_q) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				state_d = S_REPORT;
			end
			S_REPORT: begin
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// cell operation and edit outcome
	always_comb begin
		ctl.op     = CELL_HOLD;
		ctl.handle = cmd_q.item_handle;
		ctl.key    = cmd_q.arrival_key;
		ctl.pos    = cmd_q.position;
		status_a   = STAT_DONE;
		count_a    = count_q;
		pop_a      = 1'b0;
		case (state_q)
			S_IDLE: begin
				ctl.handle = cmd.payload.item_handle;
				ctl.key    = cmd.payload.arrival_key;
				if (accept && (cmd.payload.mode == MODE_INS_KEY)) begin
					ctl.op = CELL_HIT_KEY;
				end else if (accept && (cmd.payload.mode == MODE_REMOVE)) begin
					ctl.op = CELL_HIT_HANDLE;
				end
			end
			S_SCAN: begin
				ctl.op = CELL_RIPPLE;
			end
			S_APPLY: begin
				case (cmd_q.mode)
					MODE_INS_POS: begin
						if (pos_bad) begin
							status_a = STAT_BAD_POS;
						end else if (full) begin
							status_a = STAT_FULL;
						end else begin
							ctl.op  = CELL_INS_POS;
							count_a = CW'(count_q + 1'b1);
						end
					end
					MODE_INS_KEY: begin
						if (full) begin
							status_a = STAT_FULL;
						end else begin
							ctl.op  = CELL_INS_KEY;
							count_a = CW'(count_q + 1'b1);
						end
					end
					MODE_POP: begin
						if (empty) begin
							status_a = STAT_MISS;
						end else begin
							ctl.op  = CELL_POP;
							count_a = CW'(count_q - 1'b1);
							pop_a   = 1'b1;
						end
					end
					MODE_REMOVE: begin
						if (!empty && obs.found) begin
							ctl.op  = CELL_REMOVE;
							count_a = CW'(count_q - 1'b1);
						end else begin
							status_a = STAT_MISS;
						end
					end
					MODE_CLEAR: begin
						count_a = '0;
					end
					default: begin
					end
				endcase
			end
			S_REPORT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_APPLY) begin
				count_q <= count_a;
			end
			if ((state_q == S_REPORT) && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd.payload;
			step_q   <= '0;
			target_q <= (cmd.payload.mode == MODE_INS_KEY) ? CW'(count_q + 1'b1) : count_q;
		end
		if (state_q == S_SCAN) begin
			step_q <= step_inc;
		end
		if (state_q == S_APPLY) begin
			status_q     <= status_a;
			pop_valid_q  <= pop_a;
			pop_handle_q <= pop_a ? obs.head_handle : '0;
			pop_key_q    <= pop_a ? obs.head_key : '0;
		end
		if ((state_q == S_REPORT) && res_free) begin
			res_q.status        <= status_q;
			res_q.popped_valid  <= pop_valid_q;
			res_q.popped_handle <= pop_handle_q;
			res_q.popped_key    <= pop_key_q;
			res_q.entry_count   <= COUNT_OUT_W'(count_q);
			res_q.nonempty      <= !empty;
			res_q.head_handle   <= empty ? '0 : obs.head_handle;
			res_q.tail_handle   <= obs.tail_handle;
		end
	end

	assign cmd.ready   = state_q == S_IDLE;
	assign res.valid   = res_valid_q;
	assign res.payload = res_q;
	assign count       = count_q;

endmodule

`default_nettype wire

FILE: rtl/ordered_insertion_list.sv
// ---------------------------------------------------------------------------
// ordered_insertion_list
// Bounded ordered list of handle/key entries kept in a row of cells.
// ---------------------------------------------------------------------------
//
//   channel  dir  payload                                   accepted when
//   -------  ---  ----------------------------------------  ---------------
//   cmd      in   mode, position, item_handle, arrival_key  valid && ready
//   res      out  status, popped entry, count, head, tail   valid && ready
//
// Insert at position, pop and clear run through accept, edit and report.
// Insert by key and remove add a ripple between accept and edit, its
// length set by the entries held before the item, with the hit mark
// rippling one cell per cycle along the row; an insert by key into a full
// list or a remove on an empty one skips the ripple.
// Reset clears the sequencer state, the entry count and the result valid;
// cell contents are not reset and are never read past the count.
// A stalled result holds in the output register; the next item is accepted
// while it waits and runs until its own report needs that register.
//
`timescale 1ns / 1ps
`default_nettype none

module ordered_insertion_list import oil_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	oil_cmd_if.sink   cmd,
	oil_res_if.source res
);

	localparam int CW = $clog2(CAPACITY + 1);

	cell_ctl_t           ctl;
	seq_obs_t            obs;
	logic [CW-1:0]       count;
	logic [HANDLE_W-1:0] cell_handle [CAPACITY];
	logic [KEY_W-1:0]    cell_key    [CAPACITY];
	logic [HANDLE_W-1:0] tail_part   [CAPACITY];
	logic [CAPACITY-1:0] cell_mark;
	logic [CAPACITY-1:0] last_mark;
	logic [HANDLE_W-1:0] tail_or;

	// sequencer owns the count and both handshakes
	oil_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.res   (res),
		.obs   (obs),
		.ctl   (ctl),
		.count (count)
	);

	// row of cells; each sees its left and right neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [HANDLE_W-1:0] prev_handle;
		logic [KEY_W-1:0]    prev_key;
		logic                prev_mark;
		logic [HANDLE_W-1:0] next_handle;
		logic [KEY_W-1:0]    next_key;

		if (i == 0) begin : g_first
			// nothing to the left: no mark comes in, shift-up never reaches here
			assign prev_handle = '0;
			assign prev_key    = '0;
			assign prev_mark   = 1'b0;
		end else begin : g_mid
			assign prev_handle = cell_handle[i-1];
			assign prev_key    = cell_key[i-1];
			assign prev_mark   = cell_mark[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			// hold on shift-down; this slot is past the new count anyway
			assign next_handle = cell_handle[i];
			assign next_key    = cell_key[i];
		end else begin : g_inner
			assign next_handle = cell_handle[i+1];
			assign next_key    = cell_key[i+1];
		end

		oil_cell #(
			.CW (CW),
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count),
			.prev_handle(prev_handle),
			.prev_key   (prev_key),
			.prev_mark  (prev_mark),
			.next_handle(next_handle),
			.next_key   (next_key),
			.handle     (cell_handle[i]),
			.key        (cell_key[i]),
			.mark       (cell_mark[i]),
			.tail_handle(tail_part[i]),
			.last_mark  (last_mark[i])
		);
	end

	// only the cell at count-1 drives its tail and mark, so an OR selects it
	always_comb begin
		tail_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tail_or = tail_or | tail_part[i];
		end
	end

	assign obs.found       = |last_mark;
	assign obs.head_handle = cell_handle[0];
	assign obs.head_key    = cell_key[0];
	assign obs.tail_handle = tail_or;

endmodule

`default_nettype wire

FILE: rtl/ordered_insertion_list_chk.sv
// ---------------------------------------------------------------------------
// ordered_insertion_list_chk
// Port-level checks on the ordered insertion list, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_insertion_list_assert.svh"

module ordered_insertion_list_chk import oil_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	oil_cmd_if.sink   cmd,
	oil_res_if.source res
);

	// one item at a time: ready drops right after an accept
	`OIL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd.valid && cmd.ready, !cmd.ready)

	// stalled result holds
	`OIL_ASSERT_NEXT(a_res_hold, clk, arst_n, res.valid && !res.ready, res.valid && $stable(res.payload))

	// no pop: popped fields read zero
	`OIL_ASSERT_IMPL(a_pop_zero, clk, arst_n, res.valid && !res.payload.popped_valid, (res.payload.popped_handle == '0) && (res.payload.popped_key == '0))

	// a returned entry means the pop succeeded
	`OIL_ASSERT_IMPL(a_pop_status, clk, arst_n, res.valid && res.payload.popped_valid, res.payload.status == STAT_DONE)

	// empty list: count, head and tail all zero
	`OIL_ASSERT_IMPL(a_empty_view, clk, arst_n, res.valid && !res.payload.nonempty, (res.payload.entry_count == '0) && (res.payload.head_handle == '0) && (res.payload.tail_handle == '0))

endmodule

bind ordered_insertion_list ordered_insertion_list_chk u_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.cmd   (cmd),
	.res   (res)
);

`default_nettype wire
